FILE: rtl/max_pool_2d_argmax_defines.svh
// Assertion macros shared by the max pooling RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef MAX_POOL_2D_ARGMAX_DEFINES_SVH
`define MAX_POOL_2D_ARGMAX_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MP2A_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MP2A_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mp2a_pkg.sv
// Shared constants and types for the max pooling block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mp2a_pkg;

    localparam int MAX_WINDOW = 4;
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int DATA_WIDTH = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int WIN_REG_W   = 3;
    localparam int STEP_REG_W  = 3;
    localparam int DIM_REG_W   = 9;

    localparam int POSITION_W  = 16;
    localparam int OUT_INDEX_W = 8;

    localparam logic [WIN_REG_W-1:0]  WINDOW_RST = 3'd2;
    localparam logic [STEP_REG_W-1:0] STEP_RST   = 3'd2;
    localparam logic [DIM_REG_W-1:0]  WIDTH_RST  = 9'd256;
    localparam logic [DIM_REG_W-1:0]  HEIGHT_RST = 9'd256;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WINDOW_SIZE = 2'd0,
        REG_STEP_SIZE   = 2'd1,
        REG_IN_WIDTH    = 2'd2,
        REG_IN_HEIGHT   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic emit;
        logic last;
    } item_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/mp2a_cfg.sv
// Configuration registers; window and plane size saturate to their effective ranges, a zero stride follows the window.
// Depends on mp2a_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mp2a_cfg #(
    parameter int MAX_WINDOW = mp2a_pkg::MAX_WINDOW,
    parameter int MAX_WIDTH  = mp2a_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = mp2a_pkg::MAX_HEIGHT,
    localparam int WS_W = $clog2(MAX_WINDOW + 1),
    localparam int ST_W = (WS_W > mp2a_pkg::STEP_REG_W) ? WS_W : mp2a_pkg::STEP_REG_W,
    localparam int DW_W = $clog2(MAX_WIDTH + 1),
    localparam int DH_W = $clog2(MAX_HEIGHT + 1)
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [mp2a_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [mp2a_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    output logic      [WS_W-1:0]                      ws,
    output logic      [ST_W-1:0]                      st,
    output logic      [DW_W-1:0]                      w,
    output logic      [DH_W-1:0]                      h
);

    logic [mp2a_pkg::WIN_REG_W-1:0]  window_reg;
    logic [mp2a_pkg::STEP_REG_W-1:0] step_reg;
    logic [mp2a_pkg::DIM_REG_W-1:0]  width_reg;
    logic [mp2a_pkg::DIM_REG_W-1:0]  height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= mp2a_pkg::WINDOW_RST;
            step_reg   <= mp2a_pkg::STEP_RST;
            width_reg  <= mp2a_pkg::WIDTH_RST;
            height_reg <= mp2a_pkg::HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (mp2a_pkg::cfg_reg_t'(cfg_index))
                mp2a_pkg::REG_WINDOW_SIZE: begin
                    window_reg <= cfg_wr_data[mp2a_pkg::WIN_REG_W-1:0];
                end
                mp2a_pkg::REG_STEP_SIZE: begin
                    step_reg <= cfg_wr_data[mp2a_pkg::STEP_REG_W-1:0];
                end
                mp2a_pkg::REG_IN_WIDTH: begin
                    width_reg <= cfg_wr_data[mp2a_pkg::DIM_REG_W-1:0];
                end
                mp2a_pkg::REG_IN_HEIGHT: begin
                    height_reg <= cfg_wr_data[mp2a_pkg::DIM_REG_W-1:0];
                end
            endcase
        end
    end

    always_comb begin
        if (window_reg == '0) begin
            ws = WS_W'(1);
        end else if (32'(window_reg) > 32'(MAX_WINDOW)) begin
            ws = WS_W'(MAX_WINDOW);
        end else begin
            ws = WS_W'(window_reg);
        end

        // zero stride follows the window size
        if (step_reg == '0) begin
            st = ST_W'(ws);
        end else begin
            st = ST_W'(step_reg);
        end

        if (width_reg == '0) begin
            w = DW_W'(1);
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            w = DW_W'(MAX_WIDTH);
        end else begin
            w = DW_W'(width_reg);
        end

        if (height_reg == '0) begin
            h = DH_W'(1);
        end else if (32'(height_reg) > 32'(MAX_HEIGHT)) begin
            h = DH_W'(MAX_HEIGHT);
        end else begin
            h = DH_W'(height_reg);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mp2a_scan.sv
// Raster position counters: window hit detection, output indices and plane position.
// Depends on mp2a_pkg and max_pool_2d_argmax_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "max_pool_2d_argmax_defines.svh"

module mp2a_scan #(
    parameter int MAX_WINDOW = mp2a_pkg::MAX_WINDOW,
    parameter int MAX_WIDTH  = mp2a_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = mp2a_pkg::MAX_HEIGHT,
    localparam int WS_W  = $clog2(MAX_WINDOW + 1),
    localparam int ST_W  = (WS_W > mp2a_pkg::STEP_REG_W) ? WS_W : mp2a_pkg::STEP_REG_W,
    localparam int DW_W  = $clog2(MAX_WIDTH + 1),
    localparam int DH_W  = $clog2(MAX_HEIGHT + 1),
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int ROW_W = $clog2(MAX_HEIGHT),
    localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 restart,
    input  wire logic                 advance,
    input  wire logic [WS_W-1:0]      ws,
    input  wire logic [ST_W-1:0]      st,
    input  wire logic [DW_W-1:0]      w,
    input  wire logic [DH_W-1:0]      h,
    output logic      [COL_W-1:0]     col,
    output mp2a_pkg::item_ctl_t       ctl,
    output logic      [ROW_W-1:0]     orow,
    output logic      [COL_W-1:0]     ocol,
    output logic      [POS_W-1:0]     pos
);

    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [ST_W-1:0]  cph_reg;
    logic [ST_W-1:0]  rph_reg;
    logic [COL_W-1:0] ocol_reg;
    logic [ROW_W-1:0] orow_reg;
    logic [POS_W-1:0] pos_reg;

    logic             col_ok;
    logic             row_ok;
    logic             col_hit;
    logic             row_hit;
    logic             col_end;
    logic             row_end;
    logic [ST_W-1:0]  cph_next;
    logic [ST_W-1:0]  rph_next;

    always_comb begin
        col_ok  = (32'(col_reg) + 32'd1) >= 32'(ws);
        row_ok  = (32'(row_reg) + 32'd1) >= 32'(ws);
        col_hit = col_ok && (cph_reg == '0);
        row_hit = row_ok && (rph_reg == '0);
        col_end = (32'(col_reg) + 32'd1) == 32'(w);
        row_end = (32'(row_reg) + 32'd1) == 32'(h);

        cph_next = ((32'(cph_reg) + 32'd1) == 32'(st)) ? '0 : cph_reg + ST_W'(1);
        rph_next = ((32'(rph_reg) + 32'd1) == 32'(st)) ? '0 : rph_reg + ST_W'(1);

        ctl.emit = col_hit && row_hit;
        // last window of the row and of the plane: no room for another stride
        ctl.last = ((32'(col_reg) + 32'(st)) >= 32'(w)) &&
                   ((32'(row_reg) + 32'(st)) >= 32'(h));
    end

    assign col  = col_reg;
    assign orow = orow_reg;
    assign ocol = ocol_reg;
    assign pos  = pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            col_reg  <= '0;
            row_reg  <= '0;
            cph_reg  <= '0;
            rph_reg  <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
            pos_reg  <= '0;
        end else if (advance) begin
            if (col_end) begin
                col_reg  <= '0;
                cph_reg  <= '0;
                ocol_reg <= '0;
                if (row_end) begin
                    row_reg  <= '0;
                    rph_reg  <= '0;
                    orow_reg <= '0;
                    pos_reg  <= '0;
                end else begin
                    row_reg  <= row_reg + ROW_W'(1);
                    rph_reg  <= row_ok ? rph_next : '0;
                    orow_reg <= orow_reg + ROW_W'(row_hit);
                    pos_reg  <= pos_reg + POS_W'(1);
                end
            end else begin
                col_reg  <= col_reg + COL_W'(1);
                cph_reg  <= col_ok ? cph_next : '0;
                ocol_reg <= ocol_reg + COL_W'(col_hit);
                pos_reg  <= pos_reg + POS_W'(1);
            end
        end
    end

    `MP2A_ASSERT_NOW(a_scan_in_plane, aclk, aresetn, 1'b1, (32'(col_reg) < 32'(w)) && (32'(row_reg) < 32'(h)), "position counter outside the plane")

endmodule

`default_nettype wire

FILE: rtl/mp2a_lines.sv
// Line store: previous rows per column, one read and one write per cycle, registered read.
// Depends on mp2a_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mp2a_lines #(
    parameter int MAX_WINDOW = mp2a_pkg::MAX_WINDOW,
    parameter int MAX_WIDTH  = mp2a_pkg::MAX_WIDTH,
    parameter int DATA_WIDTH = mp2a_pkg::DATA_WIDTH,
    localparam int ROWS   = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1,
    localparam int LINE_W = ROWS * DATA_WIDTH,
    localparam int ADDR_W = $clog2(MAX_WIDTH)
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                rd_en,
    input  wire logic [ADDR_W-1:0]   rd_addr,
    output logic      [LINE_W-1:0]   rd_data,
    input  wire logic                wr_en,
    input  wire logic [ADDR_W-1:0]   wr_addr,
    input  wire logic [LINE_W-1:0]   wr_data
);

    logic [LINE_W-1:0] mem [MAX_WIDTH];
    logic [LINE_W-1:0] q_reg;
    logic [LINE_W-1:0] fwd_data_reg;
    logic              fwd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            q_reg        <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // read and write of the same column in one cycle: take the new word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : q_reg;

endmodule

`default_nettype wire

FILE: rtl/mp2a_win.sv
// Window register array and registered-input max tree with earliest-raster tie break.
// Depends on mp2a_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mp2a_win #(
    parameter int MAX_WINDOW = mp2a_pkg::MAX_WINDOW,
    parameter int MAX_WIDTH  = mp2a_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = mp2a_pkg::MAX_HEIGHT,
    parameter int DATA_WIDTH = mp2a_pkg::DATA_WIDTH,
    localparam int WS_W  = $clog2(MAX_WINDOW + 1),
    localparam int DW_W  = $clog2(MAX_WIDTH + 1),
    localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT),
    localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
    localparam int N     = MAX_WINDOW * MAX_WINDOW,
    localparam int NP    = 2 ** $clog2(N),
    localparam int NODES = 2 * NP - 1
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          shift_en,
    input  wire logic [MAX_WINDOW*DATA_WIDTH-1:0] col_vec,
    input  wire logic [WS_W-1:0]               ws,
    input  wire logic [DW_W-1:0]               w,
    input  wire logic [POS_W-1:0]              pos,
    output logic signed [DATA_WIDTH-1:0]       max_value,
    output logic      [POS_W-1:0]              max_pos
);

    // win_reg[row age][column age]
    logic [DATA_WIDTH-1:0] win_reg [MAX_WINDOW][MAX_WINDOW];

    logic [DATA_WIDTH-1:0] t_val [NODES];
    logic                  t_ok  [NODES];
    logic [AW-1:0]         t_ra  [NODES];
    logic [AW-1:0]         t_ca  [NODES];
    logic [POS_W-1:0]      row_off;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_WINDOW; k++) begin
                for (int c = 0; c < MAX_WINDOW; c++) begin
                    win_reg[k][c] <= '0;
                end
            end
        end else if (shift_en) begin
            for (int k = 0; k < MAX_WINDOW; k++) begin
                for (int c = MAX_WINDOW - 1; c >= 1; c--) begin
                    win_reg[k][c] <= win_reg[k][c-1];
                end
                win_reg[k][0] <= col_vec[k*DATA_WIDTH +: DATA_WIDTH];
            end
        end
    end

    // leaves in raster order, oldest row and column first
    always_comb begin
        for (int j = N; j < NP; j++) begin
            t_val[NP-1+j] = '0;
            t_ok[NP-1+j]  = 1'b0;
            t_ra[NP-1+j]  = '0;
            t_ca[NP-1+j]  = '0;
        end
        for (int rr = 0; rr < MAX_WINDOW; rr++) begin
            for (int cc = 0; cc < MAX_WINDOW; cc++) begin
                t_val[NP-1+rr*MAX_WINDOW+cc] = win_reg[MAX_WINDOW-1-rr][MAX_WINDOW-1-cc];
                t_ok[NP-1+rr*MAX_WINDOW+cc]  = ((MAX_WINDOW - 1 - rr) < int'(ws)) &&
                                               ((MAX_WINDOW - 1 - cc) < int'(ws));
                t_ra[NP-1+rr*MAX_WINDOW+cc]  = AW'(MAX_WINDOW - 1 - rr);
                t_ca[NP-1+rr*MAX_WINDOW+cc]  = AW'(MAX_WINDOW - 1 - cc);
            end
        end
        // left subtree is earlier in raster order and wins ties
        for (int i = NP - 2; i >= 0; i--) begin
            if (t_ok[2*i+2] && (!t_ok[2*i+1] ||
                    ($signed(t_val[2*i+2]) > $signed(t_val[2*i+1])))) begin
                t_val[i] = t_val[2*i+2];
                t_ok[i]  = t_ok[2*i+2];
                t_ra[i]  = t_ra[2*i+2];
                t_ca[i]  = t_ca[2*i+2];
            end else begin
                t_val[i] = t_val[2*i+1];
                t_ok[i]  = t_ok[2*i+1];
                t_ra[i]  = t_ra[2*i+1];
                t_ca[i]  = t_ca[2*i+1];
            end
        end
    end

    assign row_off   = POS_W'(32'(t_ra[0]) * 32'(w));
    assign max_value = $signed(t_val[0]);
    assign max_pos   = pos - row_off - POS_W'(t_ca[0]);

endmodule

`default_nettype wire

FILE: rtl/max_pool_2d_argmax.sv
// Top level of the 2-D max pooling block with argmax: pipeline control and result register.
// Depends on mp2a_pkg, mp2a_cfg, mp2a_scan, mp2a_lines, mp2a_win and the defines header.
//
// Takes Q8.8 pixels in raster order and, for every pixel that closes a pooling window,
// returns the window maximum, its position in the plane, the output row and column and a
// last-of-plane flag. Sustained rate is one pixel per cycle unless results stall, set by
// the line store, which does one read and one write of a column word per pixel. A result
// passes the input stage, window stage and result register after its closing pixel is
// taken. The line store needs no clearing after reset. Any register write restarts the
// plane at row 0, column 0; write registers only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
`include "max_pool_2d_argmax_defines.svh"

module max_pool_2d_argmax #(
    parameter int MAX_WINDOW = mp2a_pkg::MAX_WINDOW,
    parameter int MAX_WIDTH  = mp2a_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = mp2a_pkg::MAX_HEIGHT,
    parameter int DATA_WIDTH = mp2a_pkg::DATA_WIDTH
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                cfg_wr_en,
    input  wire logic [mp2a_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [mp2a_pkg::CFG_DATA_W-1:0]     cfg_wr_data,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [DATA_WIDTH-1:0]        s_pixel,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [DATA_WIDTH-1:0]             m_max_value,
    output logic [mp2a_pkg::POSITION_W-1:0]          m_max_position,
    output logic [mp2a_pkg::OUT_INDEX_W-1:0]         m_out_row,
    output logic [mp2a_pkg::OUT_INDEX_W-1:0]         m_out_col,
    output logic                                     m_last_of_plane
);

    localparam int WS_W   = $clog2(MAX_WINDOW + 1);
    localparam int ST_W   = (WS_W > mp2a_pkg::STEP_REG_W) ? WS_W : mp2a_pkg::STEP_REG_W;
    localparam int DW_W   = $clog2(MAX_WIDTH + 1);
    localparam int DH_W   = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int POS_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int ROWS   = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;
    localparam int LINE_W = ROWS * DATA_WIDTH;
    localparam int OUT_W  = mp2a_pkg::OUT_INDEX_W;
    localparam int POUT_W = mp2a_pkg::POSITION_W;

    logic [WS_W-1:0]  ws;
    logic [ST_W-1:0]  st;
    logic [DW_W-1:0]  w;
    logic [DH_W-1:0]  h;

    logic [COL_W-1:0]     scan_col;
    mp2a_pkg::item_ctl_t  scan_ctl;
    logic [ROW_W-1:0]     scan_orow;
    logic [COL_W-1:0]     scan_ocol;
    logic [POS_W-1:0]     scan_pos;

    // input stage
    logic                    a_valid_reg;
    logic                    a_valid_next;
    logic [DATA_WIDTH-1:0]   a_pixel_reg;
    logic [COL_W-1:0]        a_col_reg;
    mp2a_pkg::item_ctl_t     a_ctl_reg;
    logic [ROW_W-1:0]        a_orow_reg;
    logic [COL_W-1:0]        a_ocol_reg;
    logic [POS_W-1:0]        a_pos_reg;

    // window stage
    logic                    b_valid_reg;
    logic                    b_valid_next;
    mp2a_pkg::item_ctl_t     b_ctl_reg;
    logic [ROW_W-1:0]        b_orow_reg;
    logic [COL_W-1:0]        b_ocol_reg;
    logic [POS_W-1:0]        b_pos_reg;

    // result register
    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic signed [DATA_WIDTH-1:0]  m_max_value_reg;
    logic [POUT_W-1:0]             m_max_position_reg;
    logic [OUT_W-1:0]              m_out_row_reg;
    logic [OUT_W-1:0]              m_out_col_reg;
    logic                          m_last_reg;

    logic                              accept;
    logic                              out_free;
    logic                              b_leave_ok;
    logic                              b_free;
    logic                              a_move;
    logic                              out_load;
    logic [LINE_W-1:0]                 line_old;
    logic [LINE_W-1:0]                 line_new;
    logic [MAX_WINDOW*DATA_WIDTH-1:0]  col_vec;
    logic signed [DATA_WIDTH-1:0]      win_max;
    logic [POS_W-1:0]                  win_pos;

    mp2a_cfg #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .ws          (ws),
        .st          (st),
        .w           (w),
        .h           (h)
    );

    mp2a_scan #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (cfg_wr_en),
        .advance (accept),
        .ws      (ws),
        .st      (st),
        .w       (w),
        .h       (h),
        .col     (scan_col),
        .ctl     (scan_ctl),
        .orow    (scan_orow),
        .ocol    (scan_ocol),
        .pos     (scan_pos)
    );

    mp2a_lines #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_WIDTH  (MAX_WIDTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_lines (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (scan_col),
        .rd_data (line_old),
        .wr_en   (a_move),
        .wr_addr (a_col_reg),
        .wr_data (line_new)
    );

    mp2a_win #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_win (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .shift_en  (a_move),
        .col_vec   (col_vec),
        .ws        (ws),
        .w         (w),
        .pos       (b_pos_reg),
        .max_value (win_max),
        .max_pos   (win_pos)
    );

    // column of the window: current pixel, then older rows from the line store
    always_comb begin
        col_vec = '0;
        col_vec[DATA_WIDTH-1:0] = a_pixel_reg;
        for (int k = 1; k < MAX_WINDOW; k++) begin
            col_vec[k*DATA_WIDTH +: DATA_WIDTH] = line_old[(k-1)*DATA_WIDTH +: DATA_WIDTH];
        end
        line_new = '0;
        line_new[DATA_WIDTH-1:0] = a_pixel_reg;
        for (int k = 1; k < ROWS; k++) begin
            line_new[k*DATA_WIDTH +: DATA_WIDTH] = line_old[(k-1)*DATA_WIDTH +: DATA_WIDTH];
        end
    end

    always_comb begin
        out_free     = !m_valid_reg || m_ready;
        b_leave_ok   = !b_ctl_reg.emit || out_free;
        b_free       = !b_valid_reg || b_leave_ok;
        a_move       = a_valid_reg && b_free;
        s_ready      = !a_valid_reg || b_free;
        accept       = s_valid && s_ready;
        out_load     = b_valid_reg && b_ctl_reg.emit && out_free;

        a_valid_next = accept || (a_valid_reg && !a_move);
        b_valid_next = a_move || (b_valid_reg && !b_leave_ok);
        m_valid_next = out_load || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_pixel_reg <= s_pixel;
            a_col_reg   <= scan_col;
            a_ctl_reg   <= scan_ctl;
            a_orow_reg  <= scan_orow;
            a_ocol_reg  <= scan_ocol;
            a_pos_reg   <= scan_pos;
        end
        if (a_move) begin
            b_ctl_reg  <= a_ctl_reg;
            b_orow_reg <= a_orow_reg;
            b_ocol_reg <= a_ocol_reg;
            b_pos_reg  <= a_pos_reg;
        end
        if (out_load) begin
            m_max_value_reg    <= win_max;
            m_max_position_reg <= POUT_W'(32'(win_pos));
            m_out_row_reg      <= OUT_W'(32'(b_orow_reg));
            m_out_col_reg      <= OUT_W'(32'(b_ocol_reg));
            m_last_reg         <= b_ctl_reg.last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_max_value     = m_max_value_reg;
    assign m_max_position  = m_max_position_reg;
    assign m_out_row       = m_out_row_reg;
    assign m_out_col       = m_out_col_reg;
    assign m_last_of_plane = m_last_reg;

    `MP2A_ASSERT_NOW(a_empty_pipe_ready, aclk, aresetn, !a_valid_reg && !b_valid_reg, s_ready, "empty pipeline refused a request")
    `MP2A_ASSERT_NEXT(a_quiet_item_leaves, aclk, aresetn, b_valid_reg && !b_ctl_reg.emit, !b_valid_reg || $past(a_valid_reg), "item without result stuck in window stage")
    `MP2A_ASSERT_NEXT(a_stalled_item_holds, aclk, aresetn, a_valid_reg && !b_free, a_valid_reg && $stable(a_pos_reg), "stalled input stage lost its item")

endmodule

`default_nettype wire

FILE: tb/max_pool_2d_argmax_checker.sv
// Result checker for the max pooling block: predicts each window result and compares.
// Depends on mp2a_pkg; watches the configuration port and both request channels.
`timescale 1ns / 1ps

module max_pool_2d_argmax_checker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [mp2a_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [mp2a_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic signed [mp2a_pkg::DATA_WIDTH-1:0] s_pixel,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic signed [mp2a_pkg::DATA_WIDTH-1:0] m_max_value,
    input  logic [mp2a_pkg::POSITION_W-1:0]       m_max_position,
    input  logic [mp2a_pkg::OUT_INDEX_W-1:0]      m_out_row,
    input  logic [mp2a_pkg::OUT_INDEX_W-1:0]      m_out_col,
    input  logic                                  m_last_of_plane,
    output int                                    error_count,
    output int                                    pending_count
);
    import mp2a_pkg::*;

    localparam int PRINT_LIMIT = 100;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic [POSITION_W-1:0]        position;
        logic [OUT_INDEX_W-1:0]       row;
        logic [OUT_INDEX_W-1:0]       col;
        logic                         last;
    } pool_result_t;

    pool_result_t pending_windows[$];

    logic [DATA_WIDTH-1:0] line_rows [MAX_WINDOW-1][MAX_WIDTH];
    logic [DATA_WIDTH-1:0] window_grid [MAX_WINDOW][MAX_WINDOW];
    int unsigned           col_pos;
    int unsigned           row_pos;
    logic [WIN_REG_W-1:0]  window_reg;
    logic [STEP_REG_W-1:0] step_reg;
    logic [DIM_REG_W-1:0]  width_reg;
    logic [DIM_REG_W-1:0]  height_reg;

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    function automatic int unsigned clamp_dim(input logic [DIM_REG_W-1:0] raw, input int top);
        if (raw == '0)
            return 1;
        return (int'(raw) > top) ? top : int'(raw);
    endfunction

    // Shift the pixel into the line store and window, and queue a result when it
    // closes a window.
    task automatic pool_pixel(input logic [DATA_WIDTH-1:0] px);
        int unsigned           ws;
        int unsigned           st;
        int unsigned           w;
        int unsigned           h;
        int unsigned           col;
        int unsigned           row;
        int unsigned           top;
        int unsigned           left;
        int unsigned           orow;
        int unsigned           ocol;
        int unsigned           best_pos;
        int                    k;
        int                    c;
        int unsigned           a;
        int unsigned           b;
        logic [DATA_WIDTH-1:0] column_in [MAX_WINDOW];
        logic [DATA_WIDTH-1:0] raw;
        logic [DATA_WIDTH-1:0] best;
        pool_result_t          res;

        if (window_reg == '0)
            ws = 1;
        else if (window_reg > MAX_WINDOW)
            ws = MAX_WINDOW;
        else
            ws = 32'(window_reg);
        st = (step_reg == '0) ? ws : 32'(step_reg);
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        col = (col_pos >= w) ? 0 : col_pos;
        row = (row_pos >= h) ? 0 : row_pos;

        column_in[0] = px;
        for (k = 1; k < MAX_WINDOW; k++)
            column_in[k] = line_rows[k-1][col];
        for (k = MAX_WINDOW - 1; k >= 2; k--)
            line_rows[k-1][col] = line_rows[k-2][col];
        line_rows[0][col] = px;

        for (k = 0; k < MAX_WINDOW; k++) begin
            for (c = MAX_WINDOW - 1; c >= 1; c--)
                window_grid[k][c] = window_grid[k][c-1];
            window_grid[k][0] = column_in[k];
        end

        if (row + 1 >= ws && col + 1 >= ws &&
            (row + 1 - ws) % st == 0 && (col + 1 - ws) % st == 0) begin
            top = row + 1 - ws;
            left = col + 1 - ws;
            best = '0;
            best_pos = 0;
            // earliest pixel wins a tie: only a strictly larger value replaces it
            for (a = 0; a < ws; a++) begin
                for (b = 0; b < ws; b++) begin
                    raw = window_grid[ws-1-a][ws-1-b];
                    if ((a == 0 && b == 0) || $signed(raw) > $signed(best)) begin
                        best = raw;
                        best_pos = (top + a) * w + (left + b);
                    end
                end
            end
            orow = top / st;
            ocol = left / st;
            res.value = best;
            res.position = best_pos[POSITION_W-1:0];
            res.row = orow[OUT_INDEX_W-1:0];
            res.col = ocol[OUT_INDEX_W-1:0];
            res.last = (orow == (h - ws) / st) && (ocol == (w - ws) / st);
            pending_windows.push_back(res);
        end

        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h)
                row = 0;
        end
        col_pos = col;
        row_pos = row;
    endtask

    always @(posedge aclk) begin
        pool_result_t want;
        if (!aresetn) begin
            pending_windows.delete();
            foreach (line_rows[i, j])
                line_rows[i][j] = '0;
            foreach (window_grid[i, j])
                window_grid[i][j] = '0;
            col_pos = 0;
            row_pos = 0;
            window_reg = WINDOW_RST;
            step_reg = STEP_RST;
            width_reg = WIDTH_RST;
            height_reg = HEIGHT_RST;
            error_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_windows.size() == 0) begin
                    report_mismatch("result request with no window pending");
                end else begin
                    want = pending_windows.pop_front();
                    if (m_max_value !== want.value)
                        report_mismatch($sformatf("max_value %0d, want %0d",
                                                  m_max_value, want.value));
                    if (m_max_position !== want.position)
                        report_mismatch($sformatf("max_position %0d, want %0d",
                                                  m_max_position, want.position));
                    if (m_out_row !== want.row)
                        report_mismatch($sformatf("out_row %0d, want %0d",
                                                  m_out_row, want.row));
                    if (m_out_col !== want.col)
                        report_mismatch($sformatf("out_col %0d, want %0d",
                                                  m_out_col, want.col));
                    if (m_last_of_plane !== want.last)
                        report_mismatch($sformatf("last_of_plane %0b, want %0b",
                                                  m_last_of_plane, want.last));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_index))
                    REG_WINDOW_SIZE: window_reg = cfg_wr_data[WIN_REG_W-1:0];
                    REG_STEP_SIZE:   step_reg = cfg_wr_data[STEP_REG_W-1:0];
                    REG_IN_WIDTH:    width_reg = cfg_wr_data[DIM_REG_W-1:0];
                    REG_IN_HEIGHT:   height_reg = cfg_wr_data[DIM_REG_W-1:0];
                    default: ;
                endcase
                col_pos = 0;
                row_pos = 0;
            end
            if (s_valid && s_ready)
                pool_pixel(s_pixel);
        end
        pending_count = pending_windows.size();
    end

endmodule

FILE: tb/max_pool_2d_argmax_tb.sv
// Top of the max pooling testbench: clock, reset, pixel stimulus and the verdict.
// Depends on mp2a_pkg, max_pool_2d_argmax and max_pool_2d_argmax_checker.
`timescale 1ns / 1ps

module max_pool_2d_argmax_tb;
    import mp2a_pkg::*;

    localparam int RANDOM_ITEMS = 1850;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 4;
    localparam int CYCLE_LIMIT  = 400000;

    typedef enum int {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_EVERY_THIRD
    } rx_mode_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic [CFG_INDEX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_wr_data;
    logic                          s_valid;
    logic                          s_ready;
    logic signed [DATA_WIDTH-1:0]  s_pixel;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [DATA_WIDTH-1:0]  m_max_value;
    logic [POSITION_W-1:0]         m_max_position;
    logic [OUT_INDEX_W-1:0]        m_out_row;
    logic [OUT_INDEX_W-1:0]        m_out_col;
    logic                          m_last_of_plane;

    int   error_count;
    int   pending_count;
    int   cycle_count = 0;
    int   burst_left = 0;
    logic steady = 1'b1;
    logic hold_req = 1'b0;
    logic hold_taken = 1'b0;

    max_pool_2d_argmax DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel         (s_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_max_value     (m_max_value),
        .m_max_position  (m_max_position),
        .m_out_row       (m_out_row),
        .m_out_col       (m_out_col),
        .m_last_of_plane (m_last_of_plane)
    );

    max_pool_2d_argmax_checker u_window_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel         (s_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_max_value     (m_max_value),
        .m_max_position  (m_max_position),
        .m_out_row       (m_out_row),
        .m_out_col       (m_out_col),
        .m_last_of_plane (m_last_of_plane),
        .error_count     (error_count),
        .pending_count   (pending_count)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: stall pattern in spans, plus one long hold-off on request.
    initial begin
        rx_mode_t mode;
        int       span;
        int       tick;
        logic     rdy;
        m_ready = 1'b0;
        tick = 0;
        forever begin
            mode = rx_mode_t'($urandom_range(0, 3));
            span = $urandom_range(16, 96);
            repeat (span) begin
                @(negedge aclk);
                if (hold_req && !hold_taken) begin
                    hold_taken = 1'b1;
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge aclk);
                end
                tick++;
                case (mode)
                    RX_FREE:        rdy = 1'b1;
                    RX_LIGHT:       rdy = ($urandom_range(0, 9) < 7);
                    RX_HEAVY:       rdy = ($urandom_range(0, 9) < 2);
                    RX_EVERY_THIRD: rdy = (tick % 3 == 0);
                    default:        rdy = 1'b1;
                endcase
                m_ready <= rdy;
            end
        end
    end

    function automatic int dim_of(input logic [DIM_REG_W-1:0] raw, input int top);
        if (raw == '0)
            return 1;
        return (int'(raw) > top) ? top : int'(raw);
    endfunction

    function automatic logic [DATA_WIDTH-1:0] rand_pixel();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 16'h8000;
        if (pick == 1)
            return 16'h7FFF;
        // narrow range to make ties common
        if (pick < 4)
            return DATA_WIDTH'(int'($urandom_range(0, 3)) - 2);
        return DATA_WIDTH'($urandom);
    endfunction

    // One pixel request; opens a new burst when the last one ran out, after a random gap unless steady.
    task automatic send_pixel(input logic [DATA_WIDTH-1:0] px);
        int gap;
        if (burst_left == 0) begin
            gap = steady ? 0 : $urandom_range(0, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_pixel <= px;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_config(input logic [CFG_DATA_W-1:0] ws, input logic [CFG_DATA_W-1:0] st,
                                input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_WINDOW_SIZE;
        cfg_wr_data <= ws;
        @(negedge aclk);
        cfg_index <= REG_STEP_SIZE;
        cfg_wr_data <= st;
        @(negedge aclk);
        cfg_index <= REG_IN_WIDTH;
        cfg_wr_data <= w;
        @(negedge aclk);
        cfg_index <= REG_IN_HEIGHT;
        cfg_wr_data <= h;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        burst_left = 0;
    endtask

    initial begin
        int                    random_sent;
        int                    count;
        int                    plane;
        int                    shape;
        int                    k;
        logic [CFG_DATA_W-1:0] ws_raw;
        logic [CFG_DATA_W-1:0] st_raw;
        logic [CFG_DATA_W-1:0] w_raw;
        logic [CFG_DATA_W-1:0] h_raw;

        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_WINDOW_SIZE;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_pixel = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // 2x2 plane, stride taken from window; tie between two maxima
        write_config(9'd2, 9'd0, 9'd2, 9'd2);
        send_pixel(16'h8000);
        send_pixel(16'h7FFF);
        send_pixel(16'h7FFF);
        send_pixel(16'hFFFF);

        // zero window and zero width read as one
        write_config(9'd0, 9'd1, 9'd0, 9'd3);
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        send_pixel(16'h7FFF);

        // oversized window saturates to 4, stride follows it
        write_config(9'h1FE, 9'd0, 9'd4, 9'd4);
        for (k = 0; k < 16; k++)
            send_pixel((k == 5 || k == 10) ? 16'sd100 : DATA_WIDTH'(k * 3 - 20));

        // window wider than the plane: nothing comes out
        write_config(9'd3, 9'd1, 9'd2, 9'd5);
        for (k = 0; k < 4; k++)
            send_pixel(rand_pixel());

        // full-width row, a result per pixel, with the long hold-off on the result side
        write_config(9'd1, 9'd1, 9'h1FF, 9'd1);
        hold_req <= 1'b1;
        for (k = 0; k < MAX_WIDTH; k++)
            send_pixel(rand_pixel());
        random_sent = MAX_WIDTH;

        write_config(9'd1, 9'd1, 9'd1, 9'd256);
        for (k = 0; k < MAX_HEIGHT; k++)
            send_pixel(rand_pixel());
        random_sent += MAX_HEIGHT;

        while (random_sent < RANDOM_ITEMS) begin
            ws_raw = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 7))
                                                 : 9'($urandom_range(1, 4));
            k = $urandom_range(0, 9);
            if (k == 0)
                st_raw = 9'd0;
            else if (k == 1)
                st_raw = 9'($urandom_range(5, 7));
            else
                st_raw = 9'($urandom_range(1, 4));
            shape = $urandom_range(0, 31);
            if (shape == 0) begin
                w_raw = $urandom_range(0, 1) ? 9'd256 : 9'($urandom_range(257, 511));
                h_raw = 9'($urandom_range(0, 2));
            end else if (shape == 1) begin
                w_raw = 9'($urandom_range(0, 2));
                h_raw = $urandom_range(0, 1) ? 9'd256 : 9'($urandom_range(257, 511));
            end else begin
                w_raw = 9'($urandom_range(0, 12));
                h_raw = 9'($urandom_range(0, 10));
            end
            plane = dim_of(w_raw, MAX_WIDTH) * dim_of(h_raw, MAX_HEIGHT);
            count = (plane > 200) ? plane : plane * $urandom_range(1, 3);
            // sometimes break off mid-plane; the next write restarts the plane
            if (plane > 1 && $urandom_range(0, 4) == 0)
                count += $urandom_range(1, plane - 1);

            write_config(ws_raw, st_raw, w_raw, h_raw);
            steady = ($urandom_range(0, 3) == 0);
            for (k = 0; k < count; k++)
                send_pixel(rand_pixel());
            random_sent += count;
        end

        settle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/mp2a_pkg.sv
rtl/mp2a_cfg.sv
rtl/mp2a_scan.sv
rtl/mp2a_lines.sv
rtl/mp2a_win.sv
rtl/max_pool_2d_argmax.sv
tb/max_pool_2d_argmax_checker.sv
tb/max_pool_2d_argmax_tb.sv
